FILE: rtl/core/rv32e_ie_pkg.sv
// Shared types and constants for the RV32E I-type execute block.
// Opcodes, funct3 codes, status codes and the execute result struct.
// No dependencies.
`default_nettype none

package rv32e_ie_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_FENCE = 7'h0F;
  localparam logic [6:0] OP_ALUI  = 7'h13;
  localparam logic [6:0] OP_JALR  = 7'h67;
  localparam logic [6:0] OP_ECALL = 7'h73;

  localparam logic [6:0] F7_ZERO  = 7'h00;
  localparam logic [6:0] F7_ARITH = 7'h20;

  typedef enum logic [2:0] {
    F3_ADD  = 3'd0,
    F3_SLL  = 3'd1,
    F3_SLT  = 3'd2,
    F3_SLTU = 3'd3,
    F3_XOR  = 3'd4,
    F3_SR   = 3'd5,
    F3_OR   = 3'd6,
    F3_AND  = 3'd7
  } funct3_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_LOAD    = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_value;
    logic [31:0] next_pc;
  } exec_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/rv32e_ie_alu.sv
// Combinational execute logic: decode, immediate ALU, JALR target and PC step.
// Depends on rv32e_ie_pkg.
`default_nettype none

module rv32e_ie_alu
  import rv32e_ie_pkg::*;
(
  input  wire logic [6:0]  opcode,
  input  wire logic [2:0]  funct3,
  input  wire logic [4:0]  dest_index,
  input  wire logic [4:0]  src_index,
  input  wire logic [11:0] immediate,
  input  wire logic [31:0] rs_value,
  input  wire logic [31:0] pc,
  output exec_res_t        res
);

  logic [31:0] imm;
  logic [4:0]  shamt;
  logic [6:0]  f7;
  logic [31:0] a;
  logic [31:0] alu_value;
  logic        regs_ok;
  logic        bad_f7;
  logic [31:0] pc_plus4;
  logic [31:0] jump_sum;
  logic        writes;
  logic [31:0] value;

  assign imm      = {{20{immediate[11]}}, immediate};
  assign shamt    = immediate[4:0];
  assign f7       = immediate[11:5];
  assign a        = (src_index == 5'd0) ? 32'd0 : rs_value;
  assign regs_ok  = ({1'b0, dest_index} < REG_LIMIT) && ({1'b0, src_index} < REG_LIMIT);
  assign pc_plus4 = pc + 32'd4;
  assign jump_sum = a + imm;

  always_comb begin
    bad_f7 = 1'b0;
    if (funct3_t'(funct3) == F3_SLL) begin
      bad_f7 = (f7 != F7_ZERO);
    end else if (funct3_t'(funct3) == F3_SR) begin
      bad_f7 = (f7 != F7_ZERO) && (f7 != F7_ARITH);
    end
  end

  always_comb begin
    case (funct3_t'(funct3))
      F3_ADD:  alu_value = a + imm;
      F3_SLL:  alu_value = a << shamt;
      F3_SLT:  alu_value = {31'd0, $signed(a) < $signed(imm)};
      F3_SLTU: alu_value = {31'd0, a < imm};
      F3_XOR:  alu_value = a ^ imm;
      F3_SR: begin
        if (f7 == F7_ARITH) begin
          alu_value = 32'($signed(a) >>> shamt);
        end else begin
          alu_value = a >> shamt;
        end
      end
      F3_OR:   alu_value = a | imm;
      F3_AND:  alu_value = a & imm;
      default: alu_value = a & imm;
    endcase
  end

  always_comb begin
    res.status  = ST_OK;
    res.next_pc = pc;
    writes      = 1'b0;
    value       = 32'd0;
    case (opcode)
      OP_LOAD: begin
        res.status = ST_LOAD;
      end
      OP_FENCE, OP_ECALL: begin
        res.next_pc = pc_plus4;
      end
      OP_ALUI: begin
        if (bad_f7 || !regs_ok) begin
          res.status = ST_ILLEGAL;
        end else begin
          writes      = 1'b1;
          value       = alu_value;
          res.next_pc = pc_plus4;
        end
      end
      OP_JALR: begin
        if (!regs_ok) begin
          res.status = ST_ILLEGAL;
        end else begin
          writes      = 1'b1;
          value       = pc_plus4;
          res.next_pc = {jump_sum[31:1], 1'b0};
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.wr_en    = writes && (dest_index != 5'd0);
    res.wr_idx   = res.wr_en ? dest_index : 5'd0;
    res.wr_value = res.wr_en ? value : 32'd0;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rv32e_ie_state.sv
// Architectural state: register file and program counter.
// One read port, one write port. Depends on rv32e_ie_pkg.
`default_nettype none

module rv32e_ie_state
  import rv32e_ie_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [REG_IDX_W-1:0] rd_idx,
  output logic      [31:0]          rd_data,
  input  wire logic                 commit,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_idx,
  input  wire logic [31:0]          wr_data,
  input  wire logic [31:0]          pc_nxt,
  output logic      [31:0]          pc
);

  logic [31:0] regs_r [REG_COUNT];
  logic [31:0] pc_r;

  assign rd_data = regs_r[rd_idx];
  assign pc      = pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= 32'd0;
      end
      pc_r <= 32'd0;
    end else if (commit) begin
      if (wr_en) begin
        regs_r[wr_idx] <= wr_data;
      end
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rv32e_itype_execute.sv
// RV32E I-type execute block, top level: input register, execute, result register.
// Depends on rv32e_ie_pkg, rv32e_ie_alu, rv32e_ie_state.
//
//   channel | direction | ports
//   in      | in        | in_valid, in_stall(out), in_opcode .. in_immediate
//   out     | out       | out_valid, out_stall(in), out_status .. out_next_pc
//
// An input transfer loads the input register; execute then fills the result
// register. One item per cycle while the output is not stalled.
// Execute reads and writes the register file in the same cycle, so a following
// instruction sees the update with no hazard. Reset (sync, active low) clears
// register file, PC and both valid flags. Output stall holds the result and
// backs up into in_stall only once the input register is also occupied.
`default_nettype none

module rv32e_itype_execute
  import rv32e_ie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [6:0]  in_opcode,
  input  wire logic [2:0]  in_funct3,
  input  wire logic [4:0]  in_dest_index,
  input  wire logic [4:0]  in_src_index,
  input  wire logic [11:0] in_immediate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_write_enable,
  output logic [3:0]       out_write_index,
  output logic [31:0]      out_write_value,
  output logic [31:0]      out_next_pc
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [6:0]  s1_opcode_r;
  logic [2:0]  s1_funct3_r;
  logic [4:0]  s1_dest_r;
  logic [4:0]  s1_src_r;
  logic [11:0] s1_imm_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  exec_res_t   out_res_r;
  exec_res_t   res;
  logic        exec_go;
  logic        in_xfer;
  logic [31:0] rs_value;
  logic [31:0] pc;

  assign exec_go  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !exec_go;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (exec_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = exec_go ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  rv32e_ie_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (s1_src_r[REG_IDX_W-1:0]),
    .rd_data (rs_value),
    .commit  (exec_go),
    .wr_en   (res.wr_en),
    .wr_idx  (res.wr_idx[REG_IDX_W-1:0]),
    .wr_data (res.wr_value),
    .pc_nxt  (res.next_pc),
    .pc      (pc)
  );

  rv32e_ie_alu u_alu (
    .opcode     (s1_opcode_r),
    .funct3     (s1_funct3_r),
    .dest_index (s1_dest_r),
    .src_index  (s1_src_r),
    .immediate  (s1_imm_r),
    .rs_value   (rs_value),
    .pc         (pc),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_opcode_r <= in_opcode;
      s1_funct3_r <= in_funct3;
      s1_dest_r   <= in_dest_index;
      s1_src_r    <= in_src_index;
      s1_imm_r    <= in_immediate;
    end
    if (exec_go) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_write_enable = out_res_r.wr_en;
  assign out_write_index  = out_res_r.wr_idx[3:0];
  assign out_write_value  = out_res_r.wr_value;
  assign out_next_pc      = out_res_r.next_pc;

  a_pc_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pc == out_res_r.next_pc))
    else $error("PC does not match the shown result");

  a_no_write_when_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != ST_OK)) |-> !out_res_r.wr_en)
    else $error("register write on a faulting instruction");

  a_idle_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.wr_en) |->
      ((out_res_r.wr_idx == 5'd0) && (out_res_r.wr_value == 32'd0)))
    else $error("write fields not cleared without a write");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

FILE: tb/tb_rv32e_itype_execute.sv
// Self-checking testbench for the RV32E I-type execute block (ALU-immediate,
// JALR, fence, ecall, load flagging) with random idling on both channels.
// Depends on rv32e_ie_pkg and rv32e_itype_execute.
`timescale 1ns / 1ps

module tb_rv32e_itype_execute;
  import rv32e_ie_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1400;
  localparam logic [6:0] OP_UNKNOWN = 7'h7F;

  typedef struct packed {
    status_t     status;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [31:0] wr_value;
    logic [31:0] next_pc;
  } retire_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [6:0]  in_opcode;
  logic [2:0]  in_funct3;
  logic [4:0]  in_dest_index;
  logic [4:0]  in_src_index;
  logic [11:0] in_immediate;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_write_enable;
  logic [3:0]  out_write_index;
  logic [31:0] out_write_value;
  logic [31:0] out_next_pc;

  logic [31:0] arch_regs [REG_COUNT];
  logic [31:0] arch_pc;
  retire_t     retire_queue [$];
  retire_t     want;

  bit idle_on;
  int hold_left;
  int mismatches;
  int cycles;
  int sent;
  int results_seen;
  int ok_cnt;
  int illegal_cnt;
  int load_cnt;
  int jalr_cnt;

  rv32e_itype_execute dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_funct3        (in_funct3),
    .in_dest_index    (in_dest_index),
    .in_src_index     (in_src_index),
    .in_immediate     (in_immediate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_write_enable (out_write_enable),
    .out_write_index  (out_write_index),
    .out_write_value  (out_write_value),
    .out_next_pc      (out_next_pc)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, retire_queue.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // architectural state update for one transfer, pushes the retire record
  task automatic execute_instr(input logic [6:0] op, input logic [2:0] f3,
                               input logic [4:0] rd, input logic [4:0] rs,
                               input logic [11:0] imm);
    logic [31:0] imm32;
    logic [31:0] a;
    logic [31:0] value;
    logic [6:0]  f7;
    logic [4:0]  shamt;
    logic        regs_ok;
    logic        writes;
    retire_t     r;
    imm32   = {{20{imm[11]}}, imm};
    f7      = imm[11:5];
    shamt   = imm[4:0];
    regs_ok = (rd < REG_COUNT) && (rs < REG_COUNT);
    writes  = 1'b0;
    value   = '0;
    r.status = ST_OK;
    a = (rs == 5'd0 || rs >= REG_COUNT) ? 32'd0 : arch_regs[rs[3:0]];
    case (op)
      OP_LOAD: r.status = ST_LOAD;
      OP_FENCE, OP_ECALL: arch_pc = arch_pc + 32'd4;
      OP_ALUI: begin
        if ((f3 == F3_SLL && f7 != F7_ZERO) ||
            (f3 == F3_SR && f7 != F7_ZERO && f7 != F7_ARITH) || !regs_ok) begin
          r.status = ST_ILLEGAL;
        end else begin
          case (f3)
            F3_ADD:  value = a + imm32;
            F3_SLL:  value = a << shamt;
            F3_SLT:  value = ($signed(a) < $signed(imm32)) ? 32'd1 : 32'd0;
            F3_SLTU: value = (a < imm32) ? 32'd1 : 32'd0;
            F3_XOR:  value = a ^ imm32;
            F3_SR:   value = (f7 == F7_ARITH) ? 32'($signed(a) >>> shamt) : a >> shamt;
            F3_OR:   value = a | imm32;
            default: value = a & imm32;
          endcase
          writes  = 1'b1;
          arch_pc = arch_pc + 32'd4;
        end
      end
      OP_JALR: begin
        if (!regs_ok) begin
          r.status = ST_ILLEGAL;
        end else begin
          value   = arch_pc + 32'd4;
          writes  = 1'b1;
          arch_pc = (a + imm32) & 32'hFFFF_FFFE;
          jalr_cnt++;
        end
      end
      default: ;
    endcase
    if (writes && rd != 5'd0) begin
      arch_regs[rd[3:0]] = value;
    end else begin
      writes = 1'b0;
      value  = '0;
    end
    r.wr_en    = writes;
    r.wr_idx   = writes ? rd[3:0] : 4'd0;
    r.wr_value = value;
    r.next_pc  = arch_pc;
    case (r.status)
      ST_ILLEGAL: illegal_cnt++;
      ST_LOAD:    load_cnt++;
      default:    ok_cnt++;
    endcase
    retire_queue.push_back(r);
  endtask

  task automatic send_instr(input logic [6:0] op, input logic [2:0] f3,
                            input logic [4:0] rd, input logic [4:0] rs,
                            input logic [11:0] imm);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_funct3     <= f3;
    in_dest_index <= rd;
    in_src_index  <= rs;
    in_immediate  <= imm;
    do @(posedge clk); while (in_stall);
    execute_instr(op, f3, rd, rs, imm);
    sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (retire_queue.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (retire_queue.size() == 0) begin
          report_mismatch("result with nothing pending", out_next_pc, 32'd0);
        end else begin
          want = retire_queue.pop_front();
          check_field("status", 32'(out_status), 32'(want.status));
          check_field("write_enable", 32'(out_write_enable), 32'(want.wr_en));
          check_field("write_index", 32'(out_write_index), 32'(want.wr_idx));
          check_field("write_value", out_write_value, want.wr_value);
          check_field("next_pc", out_next_pc, want.next_pc);
        end
        hold_left = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_alu_immediate();
    send_instr(OP_ALUI, F3_ADD, 5'd1, 5'd0, 12'h7FF);
    send_instr(OP_ALUI, F3_ADD, 5'd2, 5'd0, 12'h800);
    send_instr(OP_ALUI, F3_ADD, 5'd3, 5'd2, 12'hFFF);
    send_instr(OP_ALUI, F3_SLT, 5'd4, 5'd2, 12'h001);
    send_instr(OP_ALUI, F3_SLTU, 5'd5, 5'd2, 12'h001);
    send_instr(OP_ALUI, F3_SLTU, 5'd5, 5'd0, 12'h001);
    send_instr(OP_ALUI, F3_XOR, 5'd6, 5'd1, 12'hFFF);
    send_instr(OP_ALUI, F3_OR, 5'd7, 5'd3, 12'h555);
    send_instr(OP_ALUI, F3_AND, 5'd8, 5'd2, 12'hAAA);
    send_instr(OP_ALUI, F3_SLL, 5'd9, 5'd1, 12'h01F);
    send_instr(OP_ALUI, F3_SR, 5'd10, 5'd2, 12'h01F);
    send_instr(OP_ALUI, F3_SR, 5'd11, 5'd2, {F7_ARITH, 5'd31});
    send_instr(OP_ALUI, F3_ADD, 5'd0, 5'd1, 12'h005);
  endtask

  task automatic test_illegal_forms();
    send_instr(OP_ALUI, F3_ADD, 5'd16, 5'd1, 12'h001);
    send_instr(OP_ALUI, F3_ADD, 5'd1, 5'd31, 12'h001);
    send_instr(OP_ALUI, F3_SLL, 5'd1, 5'd1, {F7_ARITH, 5'd1});
    send_instr(OP_ALUI, F3_SR, 5'd1, 5'd1, {7'h01, 5'd3});
    send_instr(OP_ALUI, F3_SR, 5'd1, 5'd1, {7'h7F, 5'd3});
    send_instr(OP_JALR, F3_ADD, 5'd31, 5'd1, 12'h000);
  endtask

  task automatic test_other_opcodes();
    send_instr(OP_LOAD, F3_ADD, 5'd1, 5'd1, 12'h004);
    send_instr(OP_FENCE, F3_AND, 5'd31, 5'd31, 12'hFFF);
    send_instr(OP_ECALL, F3_ADD, 5'd0, 5'd0, 12'h000);
    send_instr(OP_UNKNOWN, F3_ADD, 5'd1, 5'd1, 12'h001);
    send_instr(7'h00, F3_ADD, 5'd1, 5'd1, 12'h001);
    send_instr(OP_JALR, F3_AND, 5'd12, 5'd1, 12'h003);
    send_instr(OP_JALR, F3_ADD, 5'd1, 5'd1, 12'h801);
    send_instr(OP_JALR, F3_ADD, 5'd0, 5'd0, 12'h000);
  endtask

  task automatic test_random_stream();
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [11:0] imm;
    int pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = !(i >= 400 && i < 600);
      if (i == 700) wait_for_drain();
      op  = 7'($urandom);
      f3  = 3'($urandom);
      rd  = 5'($urandom);
      rs  = 5'($urandom);
      imm = 12'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        rd = 5'($urandom_range(0, REG_COUNT - 1));
        rs = 5'($urandom_range(0, REG_COUNT - 1));
        case ($urandom_range(0, 5))
          0: imm = 12'h7FF;
          1: imm = 12'h800;
          2: imm = 12'($urandom_range(0, 15));
          default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 75) op = OP_ALUI;
        else if (pick < 88) op = OP_JALR;
        else if (pick < 92) op = OP_FENCE;
        else if (pick < 96) op = OP_ECALL;
        else op = OP_LOAD;
        if (op == OP_ALUI && f3 == F3_SLL) imm[11:5] = F7_ZERO;
        if (op == OP_ALUI && f3 == F3_SR) imm[11:5] = $urandom_range(0, 1) ? F7_ARITH : F7_ZERO;
      end else if (pick < 90) begin
        op = $urandom_range(0, 1) ? OP_ALUI : OP_JALR;
      end
      send_instr(op, f3, rd, rs, imm);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
    arch_pc = '0;
    idle_on = 1'b1;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= '0;
    in_funct3     <= '0;
    in_dest_index <= '0;
    in_src_index  <= '0;
    in_immediate  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alu_immediate();
    test_illegal_forms();
    test_other_opcodes();
    test_random_stream();

    wait_for_drain();
    $display("%0d instructions sent, %0d results checked: %0d ok, %0d illegal, %0d load",
             sent, results_seen, ok_cnt, illegal_cnt, load_cnt);
    $display("%0d jumps taken, with random idling and a mid-run drain", jalr_cnt);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rv32e_ie_pkg.sv
rtl/core/rv32e_ie_alu.sv
rtl/core/rv32e_ie_state.sv
rtl/core/rv32e_itype_execute.sv
tb/tb_rv32e_itype_execute.sv
